FILE: sv/ohash_pkg.sv
// ohash_pkg: shared constants for the open-addressing hash table
// slot kind, command and status codes, field widths and beat layouts
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ohash_pkg;

    // default sizing
    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_TYPE_BITS = 4;

    // field widths of a request and a response
    localparam int CMD_W     = 2;
    localparam int KEY_W     = 32;
    localparam int VTYPE_W   = 4;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int KIND_W    = 2;

    // beat widths, padded to whole bytes
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;

    // slot kinds
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOMB  = 2'd2;

    // commands
    localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

    // response status
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

FILE: sv/ohash_slot_store.sv
// ohash_slot_store: slot memory of the hash table, one entry per slot
// runs a clearing sweep after reset that marks every slot empty
// depends on ohash_pkg
`timescale 1ns / 1ps
`default_nettype none

module ohash_slot_store
    import ohash_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int ENTRY_W  = KIND_W + KEY_W + DEF_TYPE_BITS + PAYLOAD_W
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
    output logic      [ENTRY_W-1:0]          rd_data,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  wire logic [ENTRY_W-1:0]          wr_data,
    output logic                             clear_busy
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = IDX_W + 1;

    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]   clr_cnt_reg;
    logic [CNT_W-1:0]   clr_cnt_next;
    logic               clr_busy_reg;
    logic               clr_busy_next;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + CNT_W'(1);
            if (clr_cnt_reg == CNT_W'(CAPACITY - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    // sweep owns the write port until every slot is empty
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[IDX_W-1:0];
            mem_wdata = {{(ENTRY_W - KIND_W){1'b0}}, KIND_EMPTY};
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

`default_nettype wire

FILE: sv/open_addressing_hash_table.sv
// Open-addressing hash table with linear probing and tombstones. Each request beat carries
// a command (get, set or delete) and a 32-bit key hash; keys match on the hash alone. One
// response beat follows every request. After reset the slot memory is swept to empty, one
// slot a cycle, so no request is taken until the sweep ends. A request that starts a probe
// passes the start state, the modulo state when needed, the issue state and the check state:
// one slot is read from the slot memory per cycle and checked by one key compare. Its
// response is loaded into the output register from the done state, when the block is ready
// again; requests are handled one at a time. When CAPACITY is not a power of two the start
// slot is found by multiplying the hash with the reciprocal of CAPACITY on one shared multiplier. Requests
// answered without a probe (empty table, set at the three-quarter load limit, unused
// command) go from the start state straight to the done state. A response that is not
// taken holds the sequencer in its final state until the output register frees; a new
// request is taken while the previous response still waits.
// depends on ohash_pkg and ohash_slot_store
`timescale 1ns / 1ps
`default_nettype none

module open_addressing_hash_table
    import ohash_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int TYPE_BITS = DEF_TYPE_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // cmd[1:0], key_hash[33:2], value_type[37:34], value_payload[101:38], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status[1:0], is_new_key[2], found_type[6:3], found_payload[70:7], zero pad
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = IDX_W + 1;
    localparam int USED_W     = IDX_W + 1;
    localparam int ENTRY_W    = KIND_W + KEY_W + TYPE_BITS + PAYLOAD_W;
    localparam int MAX_USED   = (3 * CAPACITY) / 4;
    localparam bit POW2       = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam int MOD_CYCLES = 3;
    localparam int MCNT_W     = $clog2(MOD_CYCLES);
    localparam int RECIP_W    = KEY_W + 1;
    localparam int PROD_W     = KEY_W + RECIP_W;
    localparam int SHIFT      = KEY_W + IDX_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY));
    localparam int KEY_LO     = KIND_W;
    localparam int TYPE_LO    = KIND_W + KEY_W;
    localparam int PAY_LO     = KIND_W + KEY_W + TYPE_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VTYPE_W-1:0]     vtype_reg, vtype_next;
    logic [PAYLOAD_W-1:0]   vpay_reg, vpay_next;
    logic [USED_W-1:0]      used_count_reg, used_count_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]       tomb_reg, tomb_next;
    logic                   tomb_valid_reg, tomb_valid_next;
    logic [KEY_W-1:0]       quot_reg, quot_next;
    logic [MCNT_W-1:0]      mcnt_reg, mcnt_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   is_new_reg, is_new_next;
    logic [VTYPE_W-1:0]     ftype_reg, ftype_next;
    logic [PAYLOAD_W-1:0]   fpay_reg, fpay_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [KEY_W-1:0]       mul_a;
    logic [RECIP_W-1:0]     mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [KEY_W-1:0]       mod_diff;
    logic [IDX_W-1:0]       idx_inc;
    logic [IDX_W-1:0]       rd_addr;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   clear_busy;
    logic [KIND_W-1:0]      rd_kind;
    logic [KEY_W-1:0]       rd_key;
    logic [TYPE_BITS-1:0]   rd_type;
    logic [PAYLOAD_W-1:0]   rd_pay;
    logic                   resolve;
    logic                   hit;
    logic                   slot_ok;
    logic                   fill_empty;
    logic [IDX_W-1:0]       tgt;
    logic                   tomb_now_v;
    logic [IDX_W-1:0]       tomb_now;

    ohash_slot_store #(
        .CAPACITY (CAPACITY),
        .ENTRY_W  (ENTRY_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .clear_busy (clear_busy)
    );

    assign rd_kind = rd_data[KIND_W-1:0];
    assign rd_key  = rd_data[KEY_LO +: KEY_W];
    assign rd_type = rd_data[TYPE_LO +: TYPE_BITS];
    assign rd_pay  = rd_data[PAY_LO +: PAYLOAD_W];

    assign idx_inc = (idx_reg == IDX_W'(CAPACITY - 1)) ? '0 : idx_reg + IDX_W'(1);
    // while probing, fetch the following slot so one slot is checked per cycle
    assign rd_addr = (state_reg == S_CHECK) ? idx_inc : idx_reg;

    assign s_axis_tready = (state_reg == S_IDLE) && !clear_busy;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // shared multiplier: hash times reciprocal for the quotient, then quotient times capacity
    assign mul_a    = (mcnt_reg == '0) ? key_reg : quot_reg;
    assign mul_b    = (mcnt_reg == '0) ? RECIP : RECIP_W'(CAPACITY);
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mod_diff = key_reg - quot_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        vtype_next      = vtype_reg;
        vpay_next       = vpay_reg;
        used_count_next = used_count_reg;
        idx_next        = idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        tomb_next       = tomb_reg;
        tomb_valid_next = tomb_valid_reg;
        quot_next       = quot_reg;
        mcnt_next       = mcnt_reg;
        status_next     = status_reg;
        is_new_next     = is_new_reg;
        ftype_next      = ftype_reg;
        fpay_next       = fpay_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;
        resolve         = 1'b0;
        hit             = 1'b0;
        slot_ok         = 1'b0;
        fill_empty      = 1'b0;
        tgt             = idx_reg;
        tomb_now_v      = tomb_valid_reg;
        tomb_now        = tomb_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    cmd_next   = s_axis_tdata[1:0];
                    key_next   = s_axis_tdata[33:2];
                    vtype_next = s_axis_tdata[37:34];
                    vpay_next  = s_axis_tdata[101:38];
                    state_next = S_START;
                end
            end

            S_START:
            begin
                status_next     = ST_MISS;
                is_new_next     = 1'b0;
                ftype_next      = '0;
                fpay_next       = '0;
                tomb_valid_next = 1'b0;
                probe_cnt_next  = '0;
                mcnt_next       = '0;
                if (cmd_reg == CMD_SET && used_count_reg >= USED_W'(MAX_USED))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else if (cmd_reg == CMD_SET ||
                         ((cmd_reg == CMD_GET || cmd_reg == CMD_DEL) &&
                          used_count_reg != '0))
                begin
                    if (POW2)
                    begin
                        idx_next   = key_reg[IDX_W-1:0];
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_MOD:
            begin
                mcnt_next = mcnt_reg + MCNT_W'(1);
                if (mcnt_reg == MCNT_W'(0))
                begin
                    quot_next = KEY_W'(mul_p[PROD_W-1:SHIFT]);
                end
                else if (mcnt_reg == MCNT_W'(1))
                begin
                    quot_next = mul_p[KEY_W-1:0];
                end
                else
                begin
                    idx_next   = mod_diff[IDX_W-1:0];
                    state_next = S_ISSUE;
                end
            end

            S_ISSUE:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (rd_kind == KIND_EMPTY)
                begin
                    resolve = 1'b1;
                    slot_ok = 1'b1;
                    if (tomb_valid_reg)
                    begin
                        tgt = tomb_reg;
                    end
                    else
                    begin
                        fill_empty = 1'b1;
                    end
                end
                else if (rd_kind == KIND_FULL && rd_key == key_reg)
                begin
                    resolve = 1'b1;
                    slot_ok = 1'b1;
                    hit     = 1'b1;
                end
                else
                begin
                    // a tombstone, or an unused kind, is remembered once
                    if (rd_kind != KIND_FULL && !tomb_valid_reg)
                    begin
                        tomb_next       = idx_reg;
                        tomb_valid_next = 1'b1;
                        tomb_now        = idx_reg;
                        tomb_now_v      = 1'b1;
                    end
                    if (probe_cnt_reg == CNT_W'(CAPACITY - 1))
                    begin
                        resolve = 1'b1;
                        slot_ok = tomb_now_v;
                        tgt     = tomb_now;
                    end
                    else
                    begin
                        probe_cnt_next = probe_cnt_reg + CNT_W'(1);
                        idx_next       = idx_inc;
                    end
                end

                if (resolve)
                begin
                    state_next = S_DONE;
                    wr_addr    = tgt;
                    case (cmd_reg)
                        CMD_GET:
                        begin
                            if (hit)
                            begin
                                status_next = ST_OK;
                                ftype_next  = VTYPE_W'(rd_type);
                                fpay_next   = rd_pay;
                            end
                        end
                        CMD_SET:
                        begin
                            if (slot_ok)
                            begin
                                wr_en       = 1'b1;
                                wr_data     = {vpay_reg, TYPE_BITS'(vtype_reg), key_reg,
                                               KIND_FULL};
                                is_new_next = !hit;
                                status_next = ST_OK;
                                if (fill_empty)
                                begin
                                    used_count_next = used_count_reg + USED_W'(1);
                                end
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        CMD_DEL:
                        begin
                            if (hit)
                            begin
                                wr_en       = 1'b1;
                                wr_data     = {rd_pay, rd_type, rd_key, KIND_TOMB};
                                status_next = ST_OK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, fpay_reg, ftype_reg, is_new_reg, status_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        vtype_reg      <= vtype_next;
        vpay_reg       <= vpay_next;
        idx_reg        <= idx_next;
        probe_cnt_reg  <= probe_cnt_next;
        tomb_reg       <= tomb_next;
        tomb_valid_reg <= tomb_valid_next;
        quot_reg       <= quot_next;
        mcnt_reg       <= mcnt_next;
        status_reg     <= status_next;
        is_new_reg     <= is_new_next;
        ftype_reg      <= ftype_next;
        fpay_reg       <= fpay_next;
        out_data_reg   <= out_data_next;
    end

    // the fill count never passes the load limit
    a_used_limit: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= USED_W'(MAX_USED))
        else $error("used count above load limit");

    // slot writes only come from a finished probe
    a_write_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_CHECK && !clear_busy))
        else $error("slot write outside probe check");

    // a refused set never reports a new key
    a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1:0] == ST_FULL && m_axis_tdata[2]))
        else $error("refused set marked as new key");

    // an accepted beat always starts the sequencer
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_START))
        else $error("accepted beat did not start a request");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for open_addressing_hash_table, request and response streams
// a directed table then random get/set/delete traffic, checked against a slot-level predictor
// depends on ohash_pkg and the block's rtl

module tb;
    import ohash_pkg::*;

    localparam int CAP       = DEF_CAPACITY;
    localparam int POOL_SIZE = 64;
    localparam int DIR_STEPS = 22;

    // no command is defined for this code, the block answers a miss
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [KEY_W-1:0]     key;
        logic [VTYPE_W-1:0]   vtype;
        logic [PAYLOAD_W-1:0] payload;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 is_new;
        logic [VTYPE_W-1:0]   ftype;
        logic [PAYLOAD_W-1:0] fpay;
    } response_t;

    typedef struct packed {
        request_t  req;
        logic      typed;
        response_t rsp;
    } step_t;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PAT1 = 64'hA5A5_A5A5_A5A5_A5A5;
    localparam logic [63:0] PAT2 = 64'h5A5A_5A5A_5A5A_5A5A;

    // rows with typed = 0 take their expectation from the predictor
    localparam step_t STEPS [DIR_STEPS] = '{
        '{'{CMD_GET,  32'h0000_0000, 4'h0, 64'h0}, 1'b1, '{ST_MISS, 1'b0, 4'h0, 64'h0}},
        '{'{CMD_DEL,  32'hFFFF_FFFF, 4'h0, 64'h0}, 1'b1, '{ST_MISS, 1'b0, 4'h0, 64'h0}},
        '{'{CMD_NONE, 32'h1234_5678, 4'hA, PAT1},  1'b1, '{ST_MISS, 1'b0, 4'h0, 64'h0}},
        '{'{CMD_SET,  32'h0000_0000, 4'h0, 64'h0}, 1'b1, '{ST_OK,   1'b1, 4'h0, 64'h0}},
        '{'{CMD_SET,  32'hFFFF_FFFF, 4'hF, ONES},  1'b1, '{ST_OK,   1'b1, 4'h0, 64'h0}},
        '{'{CMD_GET,  32'hFFFF_FFFF, 4'h0, 64'h0}, 1'b1, '{ST_OK,   1'b0, 4'hF, ONES}},
        '{'{CMD_GET,  32'h0000_0000, 4'h0, 64'h0}, 1'b1, '{ST_OK,   1'b0, 4'h0, 64'h0}},
        '{'{CMD_SET,  32'h0000_0100, 4'h5, PAT1},  1'b1, '{ST_OK,   1'b1, 4'h0, 64'h0}},
        '{'{CMD_SET,  32'h0000_0200, 4'hA, PAT2},  1'b1, '{ST_OK,   1'b1, 4'h0, 64'h0}},
        '{'{CMD_GET,  32'h0000_0200, 4'h0, 64'h0}, 1'b1, '{ST_OK,   1'b0, 4'hA, PAT2}},
        '{'{CMD_DEL,  32'h0000_0100, 4'h0, 64'h0}, 1'b1, '{ST_OK,   1'b0, 4'h0, 64'h0}},
        '{'{CMD_GET,  32'h0000_0100, 4'h0, 64'h0}, 1'b1, '{ST_MISS, 1'b0, 4'h0, 64'h0}},
        '{'{CMD_GET,  32'h0000_0200, 4'h0, 64'h0}, 1'b0, '0},
        '{'{CMD_SET,  32'h0000_0300, 4'h3, 64'h0123_4567_89AB_CDEF}, 1'b0, '0},
        '{'{CMD_SET,  32'h0000_0200, 4'h7, 64'hFEDC_BA98_7654_3210}, 1'b1,
          '{ST_OK, 1'b0, 4'h0, 64'h0}},
        '{'{CMD_GET,  32'h0000_0200, 4'h0, 64'h0}, 1'b0, '0},
        '{'{CMD_SET,  32'h8000_01FF, 4'hC, 64'h8000_0000_0000_0001}, 1'b0, '0},
        '{'{CMD_GET,  32'h8000_01FF, 4'h0, 64'h0}, 1'b0, '0},
        '{'{CMD_DEL,  32'h0000_0000, 4'h0, 64'h0}, 1'b1, '{ST_OK,   1'b0, 4'h0, 64'h0}},
        '{'{CMD_GET,  32'h8000_01FF, 4'h0, 64'h0}, 1'b0, '0},
        '{'{CMD_DEL,  32'h7FFF_FF00, 4'h0, 64'h0}, 1'b1, '{ST_MISS, 1'b0, 4'h0, 64'h0}},
        '{'{CMD_NONE, 32'hFFFF_FFFF, 4'hF, ONES},  1'b1, '{ST_MISS, 1'b0, 4'h0, 64'h0}}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow of the slot store
    logic [KIND_W-1:0]      slot_kind [CAP];
    logic [KEY_W-1:0]       slot_key  [CAP];
    logic [VTYPE_W-1:0]     slot_type [CAP];
    logic [PAYLOAD_W-1:0]   slot_pay  [CAP];
    int                     fill_count;

    response_t              pending_rsp [$];
    int                     err_count;
    bit                     no_idle;

    always #2 clk = ~clk;

    open_addressing_hash_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // linear probe from the home slot; returns CAP when nothing usable was met
    function automatic int probe_slot(input logic [KEY_W-1:0] key, output bit hit);
        int idx;
        int tomb;
        hit  = 1'b0;
        idx  = int'(key % 32'(CAP));
        tomb = CAP;
        for (int n = 0; n < CAP; n++)
        begin
            if (slot_kind[idx] == KIND_EMPTY)
                return (tomb != CAP) ? tomb : idx;
            if (slot_kind[idx] == KIND_FULL)
            begin
                if (slot_key[idx] == key)
                begin
                    hit = 1'b1;
                    return idx;
                end
            end
            else if (tomb == CAP)
                tomb = idx;
            idx = (idx + 1) % CAP;
        end
        return tomb;
    endfunction

    function automatic bool_over_limit();
        return 4 * (fill_count + 1) > 3 * CAP;
    endfunction

    function automatic response_t apply_request(input request_t req);
        response_t rsp;
        bit        hit;
        int        s;
        rsp        = '0;
        rsp.status = ST_MISS;
        case (req.cmd)
            CMD_GET:
                if (fill_count != 0)
                begin
                    s = probe_slot(req.key, hit);
                    if (hit)
                    begin
                        rsp.status = ST_OK;
                        rsp.ftype  = slot_type[s];
                        rsp.fpay   = slot_pay[s];
                    end
                end
            CMD_SET:
                if (bool_over_limit())
                    rsp.status = ST_FULL;
                else
                begin
                    s = probe_slot(req.key, hit);
                    if (s >= CAP)
                        rsp.status = ST_FULL;
                    else
                    begin
                        if (!hit)
                        begin
                            rsp.is_new = 1'b1;
                            if (slot_kind[s] == KIND_EMPTY)
                                fill_count++;
                        end
                        slot_kind[s] = KIND_FULL;
                        slot_key[s]  = req.key;
                        slot_type[s] = req.vtype;
                        slot_pay[s]  = req.payload;
                        rsp.status   = ST_OK;
                    end
                end
            CMD_DEL:
                if (fill_count != 0)
                begin
                    s = probe_slot(req.key, hit);
                    if (hit)
                    begin
                        slot_kind[s] = KIND_TOMB;
                        rsp.status   = ST_OK;
                    end
                end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t ns", what, got, want, $time);
        err_count++;
    endtask

    task automatic check_response(input response_t got);
        response_t want;
        if (pending_rsp.size() == 0)
        begin
            report_mismatch("beat with nothing pending", 64'(got.status), 64'(ST_MISS));
            return;
        end
        want = pending_rsp.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.is_new !== want.is_new)
            report_mismatch("is_new_key", 64'(got.is_new), 64'(want.is_new));
        if (got.ftype !== want.ftype)
            report_mismatch("found_type", 64'(got.ftype), 64'(want.ftype));
        if (got.fpay !== want.fpay)
            report_mismatch("found_payload", got.fpay, want.fpay);
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_request(input request_t req, input bit typed, input response_t typed_rsp);
        int        gap;
        response_t rsp;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({req.payload, req.vtype, req.key, req.cmd});
        do @(posedge clk); while (!s_axis_tready);
        rsp = apply_request(req);
        pending_rsp.push_back(typed ? typed_rsp : rsp);
        @(negedge clk);
    endtask

    task automatic send_random(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        request_t req;
        req.cmd     = cmd;
        req.key     = key;
        req.vtype   = 4'($urandom);
        req.payload = {32'($urandom), 32'($urandom)};
        send_request(req, 1'b0, '0);
    endtask

    task automatic drain_pending();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending_rsp.size() != 0);
    endtask

    initial
    begin : response_sink
        int        stall;
        response_t got;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            got.status = m_axis_tdata[1:0];
            got.is_new = m_axis_tdata[2];
            got.ftype  = m_axis_tdata[6:3];
            got.fpay   = m_axis_tdata[70:7];
            check_response(got);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        int               r;
        int               n_fill;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        no_idle       = 1'b0;
        err_count     = 0;
        fill_count    = 0;
        for (int i = 0; i < CAP; i++)
            slot_kind[i] = KIND_EMPTY;
        // pool keys cluster on homes that wrap past the top slot, so chains collide
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i][31:8] = 24'($urandom);
            key_pool[i][7:0]  = 8'(240 + $urandom_range(0, 31));
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_STEPS; i++)
            send_request(STEPS[i].req, STEPS[i].typed, STEPS[i].rsp);

        // churn on a small key set: hits, tombstones and their reuse
        for (int i = 0; i < 1450; i++)
        begin
            no_idle = ((i / 150) % 4) == 2;
            if (i == 700)
                drain_pending();
            r   = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 40)
                send_random(CMD_SET, key);
            else if (r < 72)
                send_random(CMD_GET, key);
            else if (r < 92)
                send_random(CMD_DEL, key);
            else if (r < 96)
                send_random(CMD_NONE, key);
            else
                send_random(2'($urandom_range(0, 2)), 32'($urandom));
        end
        no_idle = 1'b0;

        // fill with fresh keys up to the load limit
        n_fill = 0;
        while (!bool_over_limit() && n_fill < 400)
        begin
            send_random(CMD_SET, 32'($urandom));
            n_fill++;
        end

        // at the limit: sets refused even for present keys, long probes for the rest
        for (int i = 0; i < 300; i++)
        begin
            no_idle = (i >= 100 && i < 160);
            r   = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 20)
                send_random(CMD_SET, key);
            else if (r < 40)
                send_random(CMD_SET, 32'($urandom));
            else if (r < 65)
                send_random(CMD_GET, key);
            else if (r < 80)
                send_random(CMD_GET, 32'($urandom));
            else if (r < 95)
                send_random(CMD_DEL, key);
            else
                send_random(CMD_NONE, 32'($urandom));
        end
        no_idle = 1'b0;

        drain_pending();
        repeat (300) @(posedge clk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
